@@ hw/rtl/smi_pkg.sv @@
package smi_pkg;

    localparam int MAX_N_DEF     = 4;
    localparam int FRAC_BITS_DEF = 16;

    localparam int ELEM_W = 32;
    localparam int CFG_W  = 3;

    localparam logic [CFG_W-1:0]  SIZE_RST = 3'd4;
    localparam logic [ELEM_W-1:0] Q_MAX    = 32'h7fff_ffff;
    localparam logic [ELEM_W-1:0] Q_MIN    = 32'h8000_0000;

endpackage

@@ hw/rtl/small_matrix_inverse.sv @@
// Load: n*n elements, one per cycle while no size write is pending; one matrix at a time.
// Compute starts after the last one. Each minor of order m walks n^m column tuples, and
// each permutation reads, latches and multiplies its m factors in the 32x32 limb multiplier.
// Each inverse element then passes through the bit-serial divider and its output
// transaction; singular results skip the divider.
// Reset: matrix_size 4, load count 0, FSM to load; element store not cleared.
module small_matrix_inverse #(
    parameter int MAX_N     = smi_pkg::MAX_N_DEF,
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [smi_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [smi_pkg::ELEM_W-1:0] s_axis_tdata,   // element
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [smi_pkg::ELEM_W-1:0] m_axis_tdata,   // value
    output logic [0:0]                 m_axis_tuser,   // singular
    output logic                       m_axis_tlast
);

    localparam int EW     = smi_pkg::ELEM_W;
    localparam int NSTORE = MAX_N * MAX_N;
    localparam int AW     = (NSTORE > 1) ? $clog2(NSTORE) : 1;
    localparam int CNT_W  = $clog2(NSTORE + 1);
    localparam int N_W    = $clog2(MAX_N + 1);
    localparam int DIG_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int PROD_W = EW * MAX_N;
    // room for up to 6! signed terms
    localparam int ACC_W  = PROD_W + 12;
    localparam int NUM_W  = ACC_W + 2 * FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0_0000_0000_0001,
        S_CHECK = 13'b0_0000_0000_0010,
        S_READ  = 13'b0_0000_0000_0100,
        S_LATCH = 13'b0_0000_0000_1000,
        S_MUL   = 13'b0_0000_0001_0000,
        S_ACCUM = 13'b0_0000_0010_0000,
        S_NEXT  = 13'b0_0000_0100_0000,
        S_MINOR = 13'b0_0000_1000_0000,
        S_DIV   = 13'b0_0001_0000_0000,
        S_FIN   = 13'b0_0010_0000_0000,
        S_SRD   = 13'b0_0100_0000_0000,
        S_SLAT  = 13'b0_1000_0000_0000,
        S_OUT   = 13'b1_0000_0000_0000
    } t_state;

    t_state                   r_state;
    logic [smi_pkg::CFG_W-1:0] r_size;
    logic [CNT_W-1:0]         r_load_cnt;
    logic [EW-1:0]            mem [NSTORE];
    logic [EW-1:0]            r_rdata;
    logic [DIG_W-1:0]         r_dig [MAX_N];
    logic [DIG_W-1:0]         n_dig [MAX_N];
    logic                     r_skip_en;
    logic [DIG_W-1:0]         r_ri;
    logic [DIG_W-1:0]         r_ci;
    logic [MAX_N-1:0]         r_pend;
    logic [EW-1:0]            r_mag;
    logic                     r_psign;
    logic [PROD_W-1:0]        r_prod;
    logic [EW-1:0]            r_carry;
    logic [DIG_W-1:0]         r_limb;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_det;
    logic [NUM_W-1:0]         r_num;
    logic [ACC_W-1:0]         r_den;
    logic [ACC_W-1:0]         r_rem;
    logic [EW-1:0]            r_q;
    logic                     r_qovf;
    logic                     r_qneg;
    logic [DCNT_W-1:0]        r_dcnt;
    logic [CNT_W-1:0]         r_oidx;
    logic [EW-1:0]            r_oval;
    logic                     r_osing;
    logic                     r_olast;

    logic [N_W-1:0]           n_eff;
    logic [CNT_W-1:0]         n_cnt;
    logic [CNT_W-1:0]         load_idx;
    logic                     in_acc;
    logic                     cfg_acc;
    logic [MAX_N-1:0]         act;
    logic                     tup_ok;
    logic                     tup_par;
    logic                     carry;
    logic                     wrap;
    logic [DIG_W-1:0]         k_low;
    logic [AW-1:0]            rd_addr;
    logic [63:0]              mul_p;
    logic [PROD_W+EW-1:0]     prod_rot;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W:0]           rem2;
    logic [ACC_W:0]           rem_sub;
    logic                     q_ge;
    logic                     at_end;

    // a pending size write takes precedence; no element is taken beside it
    assign s_axis_tready = (r_state == S_LOAD) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_osing;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        if (r_size == '0) begin
            n_eff = N_W'(1);
        end else if (int'(r_size) > MAX_N) begin
            n_eff = N_W'(MAX_N);
        end else begin
            n_eff = N_W'(r_size);
        end
    end

    assign n_cnt    = CNT_W'(int'(n_eff) * int'(n_eff));
    assign load_idx = (r_load_cnt >= n_cnt) ? '0 : r_load_cnt;
    assign at_end   = (int'(r_ri) == int'(n_eff) - 1) && (int'(r_ci) == int'(n_eff) - 1);

    // tuple check, permutation parity, odometer step, next factor row
    always_comb begin
        for (int i = 0; i < MAX_N; i++) begin
            act[i] = (i < int'(n_eff)) && !(r_skip_en && int'(r_ci) == i);
        end
        tup_ok  = 1'b1;
        tup_par = 1'b0;
        for (int i = 0; i < MAX_N; i++) begin
            if (act[i] && r_skip_en && r_dig[i] == r_ri) begin
                tup_ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_N; j++) begin
                if (act[i] && act[j]) begin
                    if (r_dig[i] == r_dig[j]) begin
                        tup_ok = 1'b0;
                    end
                    if (r_dig[i] > r_dig[j]) begin
                        tup_par = !tup_par;
                    end
                end
            end
        end
        n_dig = r_dig;
        carry = 1'b1;
        for (int i = MAX_N - 1; i >= 0; i--) begin
            if (act[i] && carry) begin
                if (int'(r_dig[i]) == int'(n_eff) - 1) begin
                    n_dig[i] = '0;
                end else begin
                    n_dig[i] = r_dig[i] + 1'b1;
                    carry    = 1'b0;
                end
            end
        end
        wrap  = carry;
        k_low = '0;
        for (int i = MAX_N - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                k_low = DIG_W'(i);
            end
        end
    end

    always_comb begin
        if (r_state == S_READ) begin
            rd_addr = AW'(int'(k_low) * int'(n_eff) + int'(r_dig[k_low]));
        end else begin
            rd_addr = AW'(r_oidx);
        end
    end

    // one 32-bit limb per cycle; the product rotates through the low limb
    assign mul_p    = {32'd0, r_prod[EW-1:0]} * {32'd0, r_mag} + {32'd0, r_carry};
    assign prod_rot = {mul_p[EW-1:0], r_prod};
    assign prod_ext = ACC_W'(r_prod);
    assign n_acc    = r_psign ? (r_acc - prod_ext) : (r_acc + prod_ext);
    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    assign rem2    = {r_rem, r_num[NUM_W-1]};
    assign q_ge    = (rem2 >= {1'b0, r_den});
    assign rem_sub = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[AW'(load_idx)] <= s_axis_tdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_size     <= smi_pkg::SIZE_RST;
            r_load_cnt <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (cfg_acc) begin
                        r_size     <= i_cfg_data;
                        r_load_cnt <= '0;
                    end else if (in_acc) begin
                        if (load_idx + 1'b1 == n_cnt) begin
                            r_load_cnt <= '0;
                            r_skip_en  <= 1'b0;
                            r_acc      <= '0;
                            r_dig      <= '{default: '0};
                            r_state    <= S_CHECK;
                        end else begin
                            r_load_cnt <= load_idx + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (tup_ok) begin
                        r_prod  <= PROD_W'(1);
                        r_psign <= tup_par;
                        r_pend  <= act;
                        r_state <= (act == '0) ? S_ACCUM : S_READ;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_READ: begin
                    r_pend[k_low] <= 1'b0;
                    r_state       <= S_LATCH;
                end
                S_LATCH: begin
                    r_mag   <= r_rdata[EW-1] ? (32'd0 - r_rdata) : r_rdata;
                    r_psign <= r_psign ^ r_rdata[EW-1];
                    r_carry <= '0;
                    r_limb  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod_rot[PROD_W+EW-1:EW];
                    r_carry <= mul_p[63:32];
                    r_limb  <= r_limb + 1'b1;
                    if (int'(r_limb) == MAX_N - 1) begin
                        r_state <= (r_pend == '0) ? S_ACCUM : S_READ;
                    end
                end
                S_ACCUM: begin
                    r_acc   <= n_acc;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_dig   <= n_dig;
                    r_state <= wrap ? S_MINOR : S_CHECK;
                end
                S_MINOR: begin
                    if (!r_skip_en) begin
                        r_det <= r_acc;
                        r_den <= acc_mag;
                        if (r_acc == '0) begin
                            r_oidx  <= '0;
                            r_osing <= 1'b1;
                            r_state <= S_SRD;
                        end else begin
                            r_osing   <= 1'b0;
                            r_skip_en <= 1'b1;
                            r_ri      <= '0;
                            r_ci      <= '0;
                            r_acc     <= '0;
                            r_state   <= S_CHECK;
                        end
                    end else begin
                        r_num   <= NUM_W'(acc_mag) << (2 * FRAC_BITS);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_qovf  <= 1'b0;
                        // cofactor sign (-1)^(r+c) folded into the quotient sign
                        r_qneg  <= r_acc[ACC_W-1] ^ r_ri[0] ^ r_ci[0] ^ r_det[ACC_W-1];
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= q_ge ? rem_sub[ACC_W-1:0] : rem2[ACC_W-1:0];
                    r_num  <= r_num << 1;
                    r_q    <= {r_q[EW-2:0], q_ge};
                    r_qovf <= r_qovf | r_q[EW-1];
                    r_dcnt <= r_dcnt + 1'b1;
                    if (int'(r_dcnt) == NUM_W - 1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_qovf) begin
                        r_oval <= r_qneg ? smi_pkg::Q_MIN : smi_pkg::Q_MAX;
                    end else if (r_qneg) begin
                        r_oval <= (r_q > smi_pkg::Q_MIN) ? smi_pkg::Q_MIN : (32'd0 - r_q);
                    end else begin
                        r_oval <= r_q[EW-1] ? smi_pkg::Q_MAX : r_q;
                    end
                    r_olast <= at_end;
                    r_state <= S_OUT;
                end
                S_SRD: begin
                    r_state <= S_SLAT;
                end
                S_SLAT: begin
                    r_oval  <= r_rdata;
                    r_olast <= (r_oidx == n_cnt - 1'b1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_olast) begin
                            r_state <= S_LOAD;
                        end else if (r_osing) begin
                            r_oidx  <= r_oidx + 1'b1;
                            r_state <= S_SRD;
                        end else begin
                            if (int'(r_ci) == int'(n_eff) - 1) begin
                                r_ci <= '0;
                                r_ri <= r_ri + 1'b1;
                            end else begin
                                r_ci <= r_ci + 1'b1;
                            end
                            r_acc   <= '0;
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input accepted while a result is pending");

    a_singular_det_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (r_det == '0))
        else $error("singular flag with nonzero determinant");

    a_top_limb_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && int'(r_limb) == MAX_N - 1) |-> (mul_p[63:32] == 32'd0))
        else $error("product overflowed its limbs");

endmodule
